// ===== rtl/core/bfct_pkg.sv =====
// ----------------------------------------------------------------------------
// bfct_pkg
// Shared types and constants of the bidirectional flow counter table.
// ----------------------------------------------------------------------------
package bfct_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_C = 2'd2;

    // register reset values
    localparam logic [15:0] WATCH_A_RST = 16'd53;
    localparam logic [15:0] WATCH_B_RST = 16'd80;
    localparam logic [15:0] WATCH_C_RST = 16'd7010;

    // reported bucket index width
    localparam int IDX_W = 10;

    // counter sides
    localparam logic SIDE_TOP = 1'b0;
    localparam logic SIDE_LOW = 1'b1;

    // flow tuple
    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_key;

    // one stored flow; counters indexed by side
    typedef struct packed {
        t_key             key;
        logic             orient;
        logic [1:0][31:0] bytes;
        logic [1:0][31:0] pkts;
    } t_entry;

    // lookup outcome of one bucket
    typedef struct packed {
        logic hit;   // a valid way matches
        logic fwd;   // match is in stored orientation
        logic free;  // a free way exists
    } t_lookup;

endpackage

// ===== rtl/core/bfct_way_select.sv =====
// ----------------------------------------------------------------------------
// bfct_way_select
// Compares a packet tuple against all ways of one bucket row in both
// orientations and picks the first matching way, or else the first free way.
// ----------------------------------------------------------------------------
module bfct_way_select #(
    parameter int WAYS  = 4,
    parameter int WAY_W = 2
) (
    input  logic [WAYS-1:0]           i_vld,
    input  bfct_pkg::t_entry [WAYS-1:0] i_ent,
    input  bfct_pkg::t_key            i_key,
    output bfct_pkg::t_lookup         o_lookup,
    output logic [WAY_W-1:0]          o_way
);
    import bfct_pkg::*;

    logic [WAYS-1:0] fwd_eq;
    logic [WAYS-1:0] rev_eq;
    logic [WAYS-1:0] hit_w;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic             hit_fwd;

    // per-way tuple compares
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            fwd_eq[w] = i_ent[w].key == i_key;
            rev_eq[w] = i_ent[w].key.sip == i_key.dip &&
                        i_ent[w].key.dip == i_key.sip &&
                        i_ent[w].key.sport == i_key.dport &&
                        i_ent[w].key.dport == i_key.sport;
            hit_w[w]  = i_vld[w] && (fwd_eq[w] || rev_eq[w]);
        end
    end

    // lowest way wins: scan downward so the last assignment is the lowest
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        hit_fwd  = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_w[w]) begin
                hit_way = WAY_W'(w);
                hit_fwd = fwd_eq[w];
            end
            if (!i_vld[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    assign o_lookup.hit  = |hit_w;
    assign o_lookup.fwd  = hit_fwd;
    assign o_lookup.free = ~&i_vld;
    assign o_way         = (|hit_w) ? hit_way : free_way;

endmodule

// ===== rtl/core/bidirectional_flow_counter_table_top.sv =====
// ----------------------------------------------------------------------------
// bidirectional_flow_counter_table_top
// Hashed bidirectional flow table with per-side byte and packet counters.
// ----------------------------------------------------------------------------
// Each packet header hashes to a bucket of WAYS entries in a TCP or UDP table
// held in one synchronous memory row per bucket. The bucket row is read on
// the transfer edge and the updated row is written back, with the result
// registered, once the output slot is free; the next item is taken only after
// that write back, so the single read-modify-write of the row memory keeps one
// item in flight at a time. A waiting result holds the write back until the
// output slot frees. After reset the block sweeps all 2^(BUCKET_BITS+1) rows
// (2048 at the default) of the row memory to clear every valid bit, one row a
// cycle, before taking its first item; configuration writes are taken at any
// time.
module bidirectional_flow_counter_table_top #(
    parameter int BUCKET_BITS = 10,
    parameter int WAYS        = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [bfct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // packet header in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_source_ip,
    input  logic [31:0] i_dest_ip,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic        i_is_udp,
    input  logic        i_tcp_syn,
    input  logic        i_tcp_ack,
    input  logic [15:0] i_frame_len,
    // result out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_new_flow,
    output logic        o_bucket_full,
    output logic        o_side,
    output logic [31:0] o_side_bytes,
    output logic [31:0] o_side_packets,
    output logic [2:0]  o_port_class,
    output logic [bfct_pkg::IDX_W-1:0] o_bucket_index
);
    import bfct_pkg::*;

    localparam int ROW_W = BUCKET_BITS + 1;
    localparam int ROWS  = 2 ** ROW_W;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [15:0] HASH_MASK = 16'((32'd1 << BUCKET_BITS) - 1);

    typedef struct packed {
        logic [WAYS-1:0]   vld;
        t_entry [WAYS-1:0] ent;
    } t_row;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WORK  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [ROW_W-1:0] r_clr_row;

    logic [15:0] r_watch_a, r_watch_b, r_watch_c;

    // row memory
    t_row r_mem [ROWS];
    t_row r_rd_row;
    logic             mem_we;
    logic [ROW_W-1:0] mem_wa;
    t_row             mem_wd;

    // captured item
    t_key        r_key;
    logic        r_new_side;
    logic [15:0] r_len;
    logic [ROW_W-1:0] r_row_addr;
    logic [2:0]  r_class;
    logic [IDX_W-1:0] r_bidx;

    // result slot
    logic        r_out_valid;
    logic        r_new_flow, r_full, r_side;
    logic [31:0] r_sb, r_sp;
    logic [2:0]  r_out_class;
    logic [IDX_W-1:0] r_out_bidx;

    logic        in_xfer, out_free, done;
    logic [15:0] hash, hash_m;
    logic [2:0]  cls;
    t_key        in_key;
    t_lookup     lookup;
    logic [WAY_W-1:0] way;
    t_entry      sel_ent, upd_ent;
    logic        side;
    t_row        upd_row;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_state != S_IDLE;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign done        = (r_state == S_WORK) && out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watch_a <= WATCH_A_RST;
            r_watch_b <= WATCH_B_RST;
            r_watch_c <= WATCH_C_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WATCH_A: r_watch_a <= i_cfg_data;
                CFG_WATCH_B: r_watch_b <= i_cfg_data;
                CFG_WATCH_C: r_watch_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hash, port class, tuple of the incoming header
    assign hash   = (i_source_ip[15:0] | i_dest_ip[15:0]) & (i_source_port ^ i_dest_port);
    assign hash_m = hash & HASH_MASK;
    assign in_key = '{sip: i_source_ip, dip: i_dest_ip,
                      sport: i_source_port, dport: i_dest_port};
    assign cls[0] = i_source_port == r_watch_a || i_dest_port == r_watch_a;
    assign cls[1] = i_source_port == r_watch_b || i_dest_port == r_watch_b;
    assign cls[2] = i_source_port == r_watch_c || i_dest_port == r_watch_c;

    // capture item on transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key      <= in_key;
            r_new_side <= !i_is_udp && i_tcp_syn && i_tcp_ack;
            r_len      <= i_frame_len;
            r_row_addr <= {i_is_udp, hash[BUCKET_BITS-1:0]};
            r_class    <= cls;
            r_bidx     <= hash_m[IDX_W-1:0];
        end
    end

    // control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_row == '1) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = S_WORK;
            S_WORK:  if (done) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
        end
    end

    // bucket lookup
    bfct_way_select #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_way_select (
        .i_vld    (r_rd_row.vld),
        .i_ent    (r_rd_row.ent),
        .i_key    (r_key),
        .o_lookup (lookup),
        .o_way    (way)
    );

    // counter update of the chosen way
    always_comb begin
        sel_ent = r_rd_row.ent[way];
        if (lookup.hit) begin
            side    = lookup.fwd ? sel_ent.orient : !sel_ent.orient;
            upd_ent = sel_ent;
            upd_ent.bytes[side] = sel_ent.bytes[side] + {16'd0, r_len};
            upd_ent.pkts[side]  = sel_ent.pkts[side] + 32'd1;
        end else begin
            side    = r_new_side;
            upd_ent = '0;
            upd_ent.key         = r_key;
            upd_ent.orient      = r_new_side;
            upd_ent.bytes[side] = {16'd0, r_len};
            upd_ent.pkts[side]  = 32'd1;
        end
        upd_row          = r_rd_row;
        upd_row.vld[way] = 1'b1;
        upd_row.ent[way] = upd_ent;
    end

    // memory write port: clear sweep or write back
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_row_addr;
        mem_wd = upd_row;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_row;
            mem_wd = '0;
        end else if (done && (lookup.hit || lookup.free)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_row <= r_mem[{i_is_udp, hash[BUCKET_BITS-1:0]}];
        end
    end

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_class <= r_class;
            r_out_bidx  <= r_bidx;
            if (lookup.hit || lookup.free) begin
                r_new_flow <= !lookup.hit;
                r_full     <= 1'b0;
                r_side     <= side;
                r_sb       <= upd_ent.bytes[side];
                r_sp       <= upd_ent.pkts[side];
            end else begin
                r_new_flow <= 1'b0;
                r_full     <= 1'b1;
                r_side     <= SIDE_TOP;
                r_sb       <= '0;
                r_sp       <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_flow     = r_new_flow;
    assign o_bucket_full  = r_full;
    assign o_side         = r_side;
    assign o_side_bytes   = r_sb;
    assign o_side_packets = r_sp;
    assign o_port_class   = r_out_class;
    assign o_bucket_index = r_out_bidx;

endmodule

// ===== rtl/core/bfct_checker.sv =====
// ----------------------------------------------------------------------------
// bfct_checker
// Port-level checks of the flow counter table, bound to the top level.
// ----------------------------------------------------------------------------
module bfct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_new_flow,
    input logic        o_bucket_full,
    input logic [31:0] o_side_bytes,
    input logic [31:0] o_side_packets
);

    // one item in flight: a transfer closes the input for the next cycle
    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken on back-to-back cycles");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_side_bytes) && $stable(o_side_packets)))
        else $error("stalled result changed");

    // a full bucket counts nothing
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bucket_full) |->
            (!o_new_flow && o_side_bytes == 32'd0 && o_side_packets == 32'd0))
        else $error("full bucket reported counts");

    // a new flow has seen exactly one packet
    a_new_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_new_flow) |-> (o_side_packets == 32'd1 && !o_bucket_full))
        else $error("new flow packet count not one");

endmodule

bind bidirectional_flow_counter_table_top bfct_checker u_bfct_checker (.*);
